>>> rtl/core/sdsse_pkg.sv
// Package for the signed decimal seven-segment encoder: widths, segment codes, helpers.
package sdsse_pkg;

  localparam int VALUE_W        = 32;
  localparam int SEG_W          = 7;
  localparam int CFG_W          = 3;
  // Display digits carried in one output beat; fixed by the tdata layout.
  localparam int DISP_DIGITS    = 4;
  localparam int DEFAULT_DIGITS = 4;
  // Largest magnitude ever shown is 9999.
  localparam int MAG_W          = 14;
  localparam int DIG_W          = 4;
  localparam int S_TDATA_W      = 32;
  localparam int M_TDATA_W      = 32;

  localparam logic [CFG_W-1:0] CFG_RESET = 3'd4;

  localparam logic [SEG_W-1:0] SEG_BLANK = 7'h00;
  localparam logic [SEG_W-1:0] SEG_DASH  = 7'h40;

  typedef logic [SEG_W-1:0] seg_t;
  typedef logic [DIG_W-1:0] dig_t;

  function automatic seg_t seg_of_digit(input dig_t d);
    seg_t s;
    unique case (d)
      4'd0:    s = 7'h3F;
      4'd1:    s = 7'h06;
      4'd2:    s = 7'h5B;
      4'd3:    s = 7'h4F;
      4'd4:    s = 7'h66;
      4'd5:    s = 7'h6D;
      4'd6:    s = 7'h7D;
      4'd7:    s = 7'h07;
      4'd8:    s = 7'h7F;
      4'd9:    s = 7'h6F;
      default: s = SEG_BLANK;
    endcase
    return s;
  endfunction

  function automatic int pow10(input int k);
    int p;
    p = 1;
    for (int i = 0; i < k; i++) p = p * 10;
    return p;
  endfunction

  // Largest value shown on n digits: 10^n - 1.
  function automatic logic signed [VALUE_W-1:0] upper_bound(input logic [CFG_W-1:0] n);
    logic signed [VALUE_W-1:0] b;
    unique case (n)
      3'd1:    b = 32'sd9;
      3'd2:    b = 32'sd99;
      3'd3:    b = 32'sd999;
      default: b = 32'sd9999;
    endcase
    return b;
  endfunction

  // Smallest value shown on n digits: -(10^(n-1) - 1); one digit goes to the sign.
  function automatic logic signed [VALUE_W-1:0] lower_bound(input logic [CFG_W-1:0] n);
    logic signed [VALUE_W-1:0] b;
    unique case (n)
      3'd1:    b = 32'sd0;
      3'd2:    b = -32'sd9;
      3'd3:    b = -32'sd99;
      default: b = -32'sd999;
    endcase
    return b;
  endfunction

endpackage

>>> rtl/core/signed_decimal_seven_segment_encoder.sv
// Signed decimal seven-segment encoder: one signed value in, one set of digit codes out.
//
//  channel  | dir | signals                                   | payload
//  ---------+-----+-------------------------------------------+-------------------------------
//  s_axis   | in  | s_axis_tvalid/tready/tdata                | value[31:0]
//  m_axis   | out | m_axis_tvalid/tready/tdata/tuser          | seg_digit0..3, out_of_range
//  cfg      | in  | cfg_we_i, cfg_wdata_i                     | digits_in_use[2:0]
//
//  One beat per cycle sustained while m_axis_tready holds; an accepted value passes the input
//  register, then the digit split and range check into the result register, which drives output valid.
//  The decimal split is three combinational compare-and-subtract levels.
//  Reset clears both stage valids and sets digits_in_use to 4.
//  Output stall backs up through the two stages; s_axis_tready follows m_axis_tready
//  combinationally once both stages are full.
module signed_decimal_seven_segment_encoder #(
  parameter int MAX_DIGITS = sdsse_pkg::DEFAULT_DIGITS
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [sdsse_pkg::CFG_W-1:0]      cfg_wdata_i,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // [31:0] value
  input  logic [sdsse_pkg::S_TDATA_W-1:0]  s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [6:0] seg_digit0, [13:7] seg_digit1, [20:14] seg_digit2, [27:21] seg_digit3, [31:28] 0
  output logic [sdsse_pkg::M_TDATA_W-1:0]  m_axis_tdata,
  // [0] out_of_range
  output logic                             m_axis_tuser
);

  localparam int SEG_W = sdsse_pkg::SEG_W;
  localparam int MAG_W = sdsse_pkg::MAG_W;

  logic [sdsse_pkg::CFG_W-1:0]     digits_q;
  logic                            in_valid_q;
  logic [sdsse_pkg::VALUE_W-1:0]   value_q;
  logic                            out_valid_q;
  sdsse_pkg::seg_t                 seg_q [MAX_DIGITS];
  sdsse_pkg::seg_t                 seg_d [MAX_DIGITS];
  logic                            oor_q;
  logic                            oor_d;

  logic                            out_load;
  logic                            in_load;
  logic [sdsse_pkg::CFG_W-1:0]     n_eff;
  logic                            neg;
  logic [MAG_W-1:0]                mag;
  sdsse_pkg::dig_t                 dec [sdsse_pkg::DISP_DIGITS];

  // ---------------------------------------------------------------- handshake
  assign out_load      = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !in_valid_q || out_load;
  assign in_load       = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      digits_q <= sdsse_pkg::CFG_RESET;
    end else if (cfg_we_i) begin
      digits_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (out_load) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load) begin
      value_q <= s_axis_tdata[sdsse_pkg::VALUE_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load && in_valid_q) begin
      seg_q <= seg_d;
      oor_q <= oor_d;
    end
  end

  // ---------------------------------------------------------------- encode
  always_comb begin
    if (digits_q == '0) begin
      n_eff = 3'd1;
    end else if (digits_q > 3'(MAX_DIGITS)) begin
      n_eff = 3'(MAX_DIGITS);
    end else begin
      n_eff = digits_q;
    end
  end

  always_comb begin
    logic [sdsse_pkg::VALUE_W-1:0] negv;
    negv  = '0 - value_q;
    neg   = value_q[sdsse_pkg::VALUE_W-1];
    oor_d = ($signed(value_q) > sdsse_pkg::upper_bound(n_eff)) ||
            ($signed(value_q) < sdsse_pkg::lower_bound(n_eff));
    // only meaningful when in range, so the low bits suffice
    mag   = neg ? negv[MAG_W-1:0] : value_q[MAG_W-1:0];
  end

  // Decimal split: per decade, pick the largest multiple not above the remainder.
  always_comb begin
    logic [MAG_W-1:0] rem;
    logic [MAG_W-1:0] sub;
    sdsse_pkg::dig_t  d;
    rem = mag;
    for (int k = sdsse_pkg::DISP_DIGITS - 1; k >= 1; k--) begin
      d   = '0;
      sub = '0;
      for (int j = 1; j <= 9; j++) begin
        if (rem >= MAG_W'(j * sdsse_pkg::pow10(k))) begin
          d   = 4'(j);
          sub = MAG_W'(j * sdsse_pkg::pow10(k));
        end
      end
      rem    = rem - sub;
      dec[k] = d;
    end
    dec[0] = rem[sdsse_pkg::DIG_W-1:0];
  end

  always_comb begin
    logic                        numeric;
    logic                        zero_run;
    logic [sdsse_pkg::CFG_W-1:0] idx;
    sdsse_pkg::dig_t             val;
    zero_run = 1'b1;
    for (int i = 0; i < MAX_DIGITS; i++) begin
      numeric  = !(neg && (i == 0));
      idx      = n_eff - 3'd1 - 3'(i);
      val      = dec[idx[1:0]];
      zero_run = zero_run && (!numeric || (val == '0));
      if (3'(i) >= n_eff) begin
        seg_d[i] = sdsse_pkg::SEG_BLANK;
      end else if (oor_d || !numeric) begin
        seg_d[i] = sdsse_pkg::SEG_DASH;
      end else if (zero_run && ((3'(i) + 3'd1) < n_eff)) begin
        // leading zero, never the last digit in use
        seg_d[i] = sdsse_pkg::SEG_BLANK;
      end else begin
        seg_d[i] = sdsse_pkg::seg_of_digit(val);
      end
    end
  end

  // ---------------------------------------------------------------- output pack
  always_comb begin
    m_axis_tdata = '0;
    for (int f = 0; f < MAX_DIGITS; f++) begin
      m_axis_tdata[f*SEG_W +: SEG_W] = seg_q[f];
    end
  end

  assign m_axis_tuser = oor_q;

  // ---------------------------------------------------------------- assertions
  a_oor_dash_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && oor_q) |-> (seg_q[0] == sdsse_pkg::SEG_DASH))
    else $error("out-of-range beat without dash in leftmost digit");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (in_valid_q && out_valid_q && !m_axis_tready))
    else $error("input stalled while pipeline has room");

  a_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && out_load) |=> out_valid_q)
    else $error("beat lost between input and result register");

endmodule

>>> tb/sv/signed_decimal_seven_segment_encoder_tb.sv
// Self-checking testbench for the signed decimal seven-segment encoder.
module signed_decimal_seven_segment_encoder_tb;

  localparam int HOLD_CYCLES = 300;
  localparam int VALUE_W     = sdsse_pkg::VALUE_W;
  localparam int CFG_W       = sdsse_pkg::CFG_W;
  localparam int S_TDATA_W   = sdsse_pkg::S_TDATA_W;
  localparam int M_TDATA_W   = sdsse_pkg::M_TDATA_W;

  // seg[0] is the leftmost digit
  typedef struct packed {
    logic                       oor;
    sdsse_pkg::seg_t [3:0]      seg;
  } display_t;

  typedef struct {
    logic [VALUE_W-1:0] value;
    display_t           disp;
  } pending_display_t;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 cfg_we_i      = 1'b0;
  logic [CFG_W-1:0]     cfg_wdata_i   = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic                 m_axis_tuser;

  pending_display_t pending_displays[$];
  logic [CFG_W-1:0] digits_cfg = sdsse_pkg::CFG_RESET;
  int               snd_idle_pct = 0;
  int               rcv_stall_pct = 0;
  bit               hold_req = 1'b0;
  int               hold_left = 0;
  int               mismatches = 0;

  signed_decimal_seven_segment_encoder u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  function automatic longint decade(input int k);
    case (k)
      0:       return 1;
      1:       return 10;
      2:       return 100;
      3:       return 1000;
      default: return 10000;
    endcase
  endfunction

  function automatic sdsse_pkg::seg_t digit_code(input int d);
    case (d)
      0:       return 7'h3F;
      1:       return 7'h06;
      2:       return 7'h5B;
      3:       return 7'h4F;
      4:       return 7'h66;
      5:       return 7'h6D;
      6:       return 7'h7D;
      7:       return 7'h07;
      8:       return 7'h7F;
      default: return 7'h6F;
    endcase
  endfunction

  function automatic int active_digits(input logic [CFG_W-1:0] cfg);
    if (cfg == 0) return 1;
    if (cfg > 4) return 4;
    return int'(cfg);
  endfunction

  function automatic display_t encode_display(input logic [VALUE_W-1:0] raw,
                                              input logic [CFG_W-1:0] cfg);
    display_t r;
    int       n;
    int       d;
    int       first;
    longint   v;
    longint   mag;
    bit       lead;
    r = '0;
    n = active_digits(cfg);
    v = longint'($signed(raw));
    if (v > decade(n) - 1 || v < -(decade(n - 1) - 1)) begin
      for (int i = 0; i < n; i++) r.seg[i] = sdsse_pkg::SEG_DASH;
      r.oor = 1'b1;
    end else begin
      first = 0;
      mag = v;
      if (v < 0) begin
        r.seg[0] = sdsse_pkg::SEG_DASH;
        first = 1;
        mag = -v;
      end
      lead = 1'b1;
      for (int i = first; i < n; i++) begin
        d = int'(mag / decade(n - 1 - i));
        mag = mag % decade(n - 1 - i);
        // leading zeros blank, but the last digit always shows
        if (lead && d == 0 && i < n - 1) begin
          r.seg[i] = sdsse_pkg::SEG_BLANK;
        end else begin
          r.seg[i] = digit_code(d);
          lead = 1'b0;
        end
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(input string field, input logic [VALUE_W-1:0] value,
                                 input int got, input int want);
    $display("MISMATCH %s for value %0d (digits %0d): got 0x%0h, expected 0x%0h",
             field, $signed(value), digits_cfg, got, want);
    mismatches++;
  endtask

  // Receiver: random stalls, long hold-off on request, result check.
  always @(posedge clk_i) begin
    pending_display_t want;
    display_t         got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.seg[0] = m_axis_tdata[6:0];
      got.seg[1] = m_axis_tdata[13:7];
      got.seg[2] = m_axis_tdata[20:14];
      got.seg[3] = m_axis_tdata[27:21];
      got.oor    = m_axis_tuser;
      if (pending_displays.size() == 0) begin
        report_mismatch("unexpected beat", '0, m_axis_tdata, 0);
      end else begin
        want = pending_displays.pop_front();
        for (int i = 0; i < 4; i++)
          if (got.seg[i] !== want.disp.seg[i])
            report_mismatch($sformatf("seg_digit%0d", i), want.value, got.seg[i],
                            want.disp.seg[i]);
        if (got.oor !== want.disp.oor)
          report_mismatch("out_of_range", want.value, got.oor, want.disp.oor);
        if (m_axis_tdata[31:28] !== 4'd0)
          report_mismatch("tdata pad", want.value, m_axis_tdata[31:28], 0);
      end
    end
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rcv_stall_pct);
    end
  end

  task automatic send_value(input logic [VALUE_W-1:0] v);
    int gap;
    s_axis_tdata  <= v;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_displays.push_back('{value: v, disp: encode_display(v, digits_cfg)});
    gap = 0;
    while (gap < 200 && $urandom_range(99) < snd_idle_pct) gap++;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (pending_displays.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_digits(input logic [CFG_W-1:0] n);
    drain_results();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= n;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    digits_cfg  = n;
  endtask

  // Mostly values around the display bounds, some full-width noise.
  function automatic logic [VALUE_W-1:0] random_value();
    int     n;
    int     mode;
    longint base;
    longint span;
    n = active_digits(digits_cfg);
    mode = $urandom_range(99);
    if (mode < 15) return $urandom;
    if (mode < 45) begin
      if ($urandom_range(1)) base = decade(n) - 1;
      else base = -(decade(n - 1) - 1);
      return VALUE_W'(base + $urandom_range(4) - 2);
    end
    base = -(decade(n - 1) - 1) - 3 - decade(n) / 5;
    span = decade(n) + decade(n - 1) + 6 + 2 * (decade(n) / 5);
    return VALUE_W'(base + $urandom_range(int'(span)));
  endfunction

  task automatic test_directed_values();
    snd_idle_pct  = 0;
    rcv_stall_pct = 0;
    send_value(0);
    send_value(1);
    send_value(-1);
    send_value(-5);
    send_value(1005);
    send_value(9999);
    send_value(10000);
    send_value(-999);
    send_value(-1000);
    send_value(32'h7FFF_FFFF);
    send_value(32'h8000_0000);
    set_digits(3'd1);
    send_value(9);
    send_value(10);
    send_value(0);
    send_value(-1);
    set_digits(3'd2);
    send_value(-9);
    send_value(100);
    send_value(10);
    send_value(-10);
    set_digits(3'd3);
    send_value(999);
    send_value(-100);
    // zero setting acts as one digit, large settings as four
    set_digits(3'd0);
    send_value(5);
    send_value(-1);
    set_digits(3'd7);
    send_value(-999);
    send_value(9999);
  endtask

  task automatic run_random_phase(input logic [CFG_W-1:0] n, input int count,
                                  input int idle_pct, input int stall_pct);
    set_digits(n);
    snd_idle_pct  = idle_pct;
    rcv_stall_pct = stall_pct;
    repeat (count) send_value(random_value());
  endtask

  task automatic test_random_settings();
    run_random_phase(3'd4, 130, 0, 0);
    run_random_phase(3'd1, 120, 88, 0);
    run_random_phase(3'd2, 120, 0, 88);
    run_random_phase(3'd3, 120, 10, 10);
    run_random_phase(3'd0, 100, 0, 0);
    run_random_phase(3'd7, 120, 88, 0);
    run_random_phase(3'd5, 100, 0, 88);
    run_random_phase(3'd6, 80, 10, 10);
    run_random_phase(3'd4, 120, 10, 10);
  endtask

  // Receiver holds off while the sender keeps offering, so both stages fill.
  task automatic test_output_backpressure();
    set_digits(3'd4);
    snd_idle_pct  = 0;
    rcv_stall_pct = 0;
    hold_req = 1'b1;
    repeat (30) send_value(random_value());
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_values();
    test_random_settings();
    test_output_backpressure();
    drain_results();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("signed_decimal_seven_segment_encoder verification clean");
    end else begin
      $display("signed_decimal_seven_segment_encoder verification failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("signed_decimal_seven_segment_encoder verification failed");
    $finish;
  end

endmodule
